FILE: rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and codes of the dense layer with ReLU output.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int VAL_W   = 16;
    localparam int CNT_W   = 9;
    localparam int OCNT_W  = 7;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int CIDX_W  = 2;
    localparam int RES_W   = 15;
    localparam int PROD_W  = 2 * VAL_W;

    typedef enum logic [1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_BIAS   = 2'd1,
        REQ_DATA   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_INPUT_COUNT  = 2'd0,
        CFG_OUTPUT_COUNT = 2'd1,
        CFG_SPARE_2      = 2'd2,
        CFG_SPARE_3      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    // Tag that travels with one multiply-accumulate term.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic bias;
    } term_t;

endpackage

FILE: rtl/core/dense_layer_relu.sv
// ----------------------------------------------------------------------------
// dense_layer_relu
// Fully connected layer with ReLU output in signed Q8.8 arithmetic.
//
//   Channel  Signals                                        Direction
//   item     item_valid, item_stall, req_type, row_index,   into block
//            column_index, value
//   result   result_valid, result_stall, out_value,         out of block
//            out_index, last
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data      into block
//
// Load items and data items that do not complete a vector leave the block
// idle and ready for the next item. A data item that completes a vector
// starts the compute, during which no item is taken: one term per cycle
// through the shared multiplier, the input terms first and the bias term last.
// Weights and biases share one memory whose single read port sets that pace.
// The memories need no clearing after reset; only control registers are reset.
// A stalled result holds the next output in the accumulator until it moves.
// ----------------------------------------------------------------------------
module dense_layer_relu #(
    parameter int IN_MAX  = 256,
    parameter int OUT_MAX = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         req_type,
    input  logic [dlr_pkg::ROW_W-1:0]          row_index,
    input  logic [dlr_pkg::COL_W-1:0]          column_index,
    input  logic signed [dlr_pkg::VAL_W-1:0]   value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [dlr_pkg::RES_W-1:0]          out_value,
    output logic [dlr_pkg::COL_W-1:0]          out_index,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dlr_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [dlr_pkg::CNT_W-1:0]          cfg_data
);

    localparam int WDEPTH = (IN_MAX + 1) * OUT_MAX;
    localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int IW     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int ACC_W  = dlr_pkg::PROD_W + $clog2(IN_MAX + 1) + 1;
    localparam logic [AW-1:0] BIAS_BASE = AW'(IN_MAX * OUT_MAX);
    localparam logic [AW-1:0] STRIDE    = AW'(OUT_MAX);
    localparam logic [dlr_pkg::CNT_W-1:0] IN_LIM =
        (IN_MAX > 511) ? dlr_pkg::CNT_W'(511) : dlr_pkg::CNT_W'(IN_MAX);
    localparam logic [dlr_pkg::OCNT_W-1:0] OUT_LIM = dlr_pkg::OCNT_W'(OUT_MAX);

    dlr_pkg::state_t              state_reg, state_next;
    logic [dlr_pkg::CNT_W-1:0]    input_count_reg;
    logic [dlr_pkg::OCNT_W-1:0]   output_count_reg;
    logic [dlr_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [dlr_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [dlr_pkg::COL_W-1:0]    j_reg, j_next;
    logic [AW-1:0]                waddr_reg, waddr_next;
    dlr_pkg::term_t               term_reg, term_next;

    logic                         out_valid_reg;
    logic [dlr_pkg::RES_W-1:0]    out_value_reg;
    logic [dlr_pkg::COL_W-1:0]    out_index_reg;
    logic                         out_last_reg;

    logic [dlr_pkg::CNT_W-1:0]    n_in;
    logic [dlr_pkg::OCNT_W-1:0]   n_out;
    logic                         accept;
    logic                         out_free;
    logic                         load_out;
    logic                         bias_term;
    logic                         row_ok;
    logic                         col_ok;

    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [AW-1:0]                w_rd_addr;
    logic [dlr_pkg::VAL_W-1:0]    w_rd_data;
    logic                         v_wr_en;
    logic [dlr_pkg::VAL_W-1:0]    v_rd_data;
    logic                         mac_done;
    logic [dlr_pkg::RES_W-1:0]    mac_value;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != dlr_pkg::ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (input_count_reg == '0)
        begin
            n_in = dlr_pkg::CNT_W'(1);
        end
        else if (input_count_reg > IN_LIM)
        begin
            n_in = IN_LIM;
        end
        else
        begin
            n_in = input_count_reg;
        end
        if (output_count_reg == '0)
        begin
            n_out = dlr_pkg::OCNT_W'(1);
        end
        else if (output_count_reg > OUT_LIM)
        begin
            n_out = OUT_LIM;
        end
        else
        begin
            n_out = output_count_reg;
        end
    end

    always_comb
    begin
        row_ok    = 32'(row_index) < 32'(IN_MAX);
        col_ok    = 32'(column_index) < 32'(OUT_MAX);
        w_wr_en   = 1'b0;
        w_wr_addr = BIAS_BASE + AW'(column_index);
        v_wr_en   = 1'b0;
        if (accept)
        begin
            case (req_type)
                dlr_pkg::REQ_WEIGHT:
                begin
                    w_wr_en   = row_ok && col_ok;
                    w_wr_addr = AW'(row_index) * STRIDE + AW'(column_index);
                end
                dlr_pkg::REQ_BIAS:
                begin
                    w_wr_en = col_ok;
                end
                dlr_pkg::REQ_DATA:
                begin
                    v_wr_en = 1'b1;
                end
                default:
                begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    assign bias_term = (i_reg == n_in);
    assign w_rd_addr = bias_term ? (BIAS_BASE + AW'(j_reg)) : waddr_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        waddr_next = waddr_reg;
        term_next  = '0;
        load_out   = 1'b0;
        case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (accept && (req_type == dlr_pkg::REQ_DATA))
                begin
                    if ({1'b0, count_reg} + 10'd1 >= {1'b0, n_in})
                    begin
                        count_next = '0;
                        i_next     = '0;
                        j_next     = '0;
                        waddr_next = '0;
                        state_next = dlr_pkg::ST_RUN;
                    end
                    else
                    begin
                        count_next = count_reg + dlr_pkg::CNT_W'(1);
                    end
                end
            end
            dlr_pkg::ST_RUN:
            begin
                term_next.valid = 1'b1;
                term_next.first = (i_reg == '0);
                term_next.bias  = bias_term;
                term_next.last  = bias_term;
                i_next          = i_reg + dlr_pkg::CNT_W'(1);
                waddr_next      = waddr_reg + STRIDE;
                if (bias_term)
                begin
                    state_next = dlr_pkg::ST_WAIT;
                end
            end
            dlr_pkg::ST_WAIT:
            begin
                if (mac_done && out_free)
                begin
                    load_out = 1'b1;
                    if ({1'b0, j_reg} + 7'd1 == n_out)
                    begin
                        state_next = dlr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = j_reg + dlr_pkg::COL_W'(1);
                        waddr_next = AW'(j_reg) + AW'(1);
                        state_next = dlr_pkg::ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dlr_pkg::ST_IDLE;
            input_count_reg  <= dlr_pkg::CNT_W'(256);
            output_count_reg <= dlr_pkg::OCNT_W'(64);
            count_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            waddr_reg        <= '0;
            term_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            waddr_reg <= waddr_next;
            term_reg  <= term_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dlr_pkg::CFG_INPUT_COUNT:
                    begin
                        input_count_reg <= cfg_data;
                    end
                    dlr_pkg::CFG_OUTPUT_COUNT:
                    begin
                        output_count_reg <= cfg_data[dlr_pkg::OCNT_W-1:0];
                    end
                    default:
                    begin
                        input_count_reg <= input_count_reg;
                    end
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= mac_value;
            out_index_reg <= j_reg;
            out_last_reg  <= ({1'b0, j_reg} + 7'd1 == n_out);
        end
    end

    dlr_ram #(
        .DEPTH (WDEPTH),
        .WIDTH (dlr_pkg::VAL_W),
        .AW    (AW)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (value),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    dlr_ram #(
        .DEPTH (IN_MAX),
        .WIDTH (dlr_pkg::VAL_W),
        .AW    (IW)
    ) u_vmem (
        .clk     (clk),
        .wr_en   (v_wr_en),
        .wr_addr (IW'(count_reg)),
        .wr_data (value),
        .rd_addr (IW'(i_reg)),
        .rd_data (v_rd_data)
    );

    dlr_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .term       (term_reg),
        .vec_data   ($signed(v_rd_data)),
        .wgt_data   ($signed(w_rd_data)),
        .take       (load_out),
        .done       (mac_done),
        .relu_value (mac_value)
    );

    assign result_valid = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_index    = out_index_reg;
    assign last         = out_last_reg;

endmodule

FILE: rtl/core/dlr_ram.sv
// ----------------------------------------------------------------------------
// dlr_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module dlr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/dlr_mac.sv
// ----------------------------------------------------------------------------
// dlr_mac
// Registered multiplier, wide accumulator and ReLU with saturation.
// ----------------------------------------------------------------------------
module dlr_mac #(
    parameter int ACC_W = 42
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dlr_pkg::term_t                    term,
    input  logic signed [dlr_pkg::VAL_W-1:0]  vec_data,
    input  logic signed [dlr_pkg::VAL_W-1:0]  wgt_data,
    input  logic                              take,
    output logic                              done,
    output logic [dlr_pkg::RES_W-1:0]         relu_value
);

    localparam int SHIFT = 8;
    localparam int TOP   = SHIFT + dlr_pkg::RES_W;

    dlr_pkg::term_t                      tag_reg;
    logic signed [dlr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [dlr_pkg::PROD_W-1:0]   prod_next;
    logic signed [dlr_pkg::VAL_W-1:0]    mul_a;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [ACC_W-1:0]             acc_next;
    logic                                done_reg;
    logic                                positive;
    logic                                overflow;

    always_comb
    begin
        mul_a     = term.bias ? dlr_pkg::VAL_W'(256) : vec_data;
        prod_next = mul_a * wgt_data;
        if (tag_reg.first)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg <= term;
            if (tag_reg.valid && tag_reg.last)
            begin
                done_reg <= 1'b1;
            end
            else if (take)
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        positive = !acc_reg[ACC_W-1] && (acc_reg != '0);
        overflow = |acc_reg[ACC_W-1:TOP];
        if (!positive)
        begin
            relu_value = '0;
        end
        else if (overflow)
        begin
            relu_value = '1;
        end
        else
        begin
            relu_value = acc_reg[TOP-1:SHIFT];
        end
    end

    assign done = done_reg;

endmodule

FILE: dv/dense_layer_relu_checker.sv
// ----------------------------------------------------------------------------
// dense_layer_relu_checker
// Passive checker for the dense layer with ReLU output. It watches every
// transfer on the item, result and configuration channels, keeps its own
// copy of the weights, biases, input vector and counts, computes the outputs
// of each completed vector and compares them in order with the results.
// ----------------------------------------------------------------------------
module dense_layer_relu_checker #(
    parameter int IN_MAX  = 256,
    parameter int OUT_MAX = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_stall,
    input  logic [1:0]                         req_type,
    input  logic [dlr_pkg::ROW_W-1:0]          row_index,
    input  logic [dlr_pkg::COL_W-1:0]          column_index,
    input  logic signed [dlr_pkg::VAL_W-1:0]   value,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic [dlr_pkg::RES_W-1:0]          out_value,
    input  logic [dlr_pkg::COL_W-1:0]          out_index,
    input  logic                               last,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dlr_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [dlr_pkg::CNT_W-1:0]          cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dlr_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0] level;
        logic [COL_W-1:0] neuron;
        logic             is_last;
    } neuron_out_t;

    logic signed [VAL_W-1:0] weight_mem [0:IN_MAX-1][0:OUT_MAX-1];
    logic signed [VAL_W-1:0] bias_mem [0:OUT_MAX-1];
    logic signed [VAL_W-1:0] in_vec [0:IN_MAX-1];
    logic [CNT_W-1:0]        in_cnt;
    logic [OCNT_W-1:0]       out_cnt;
    int                      data_cnt;
    neuron_out_t             expected_outputs [$];

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk)
    begin : watch
        neuron_out_t        got;
        neuron_out_t        want;
        logic signed [63:0] acc;
        int                 n_in;
        int                 n_out;
        int                 i;
        int                 j;
        if (!rst_n)
        begin
            in_cnt   = 9'd256;
            out_cnt  = 7'd64;
            data_cnt = 0;
            expected_outputs.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got = '{level: out_value, neuron: out_index, is_last: last};
                if (expected_outputs.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: value %0d index %0d last %0d",
                                           got.level, got.neuron, got.is_last));
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (got.level !== want.level || got.neuron !== want.neuron ||
                        got.is_last !== want.is_last)
                    begin
                        note_failure($sformatf(
                            "mismatch: expected value %0d index %0d last %0d, got value %0d index %0d last %0d",
                            want.level, want.neuron, want.is_last,
                            got.level, got.neuron, got.is_last));
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INPUT_COUNT:  in_cnt  = cfg_data;
                    CFG_OUTPUT_COUNT: out_cnt = cfg_data[OCNT_W-1:0];
                    default: ;
                endcase
            end

            if (item_valid && !item_stall)
            begin
                case (req_type)
                    REQ_WEIGHT: weight_mem[row_index][column_index] = value;
                    REQ_BIAS:   bias_mem[column_index] = value;
                    REQ_DATA:
                    begin
                        n_in = (in_cnt == 0) ? 1 : ((in_cnt > IN_MAX) ? IN_MAX : int'(in_cnt));
                        if (data_cnt < IN_MAX)
                        begin
                            in_vec[data_cnt] = value;
                        end
                        data_cnt++;
                        if (data_cnt >= n_in)
                        begin
                            data_cnt = 0;
                            n_out = (out_cnt == 0) ? 1 :
                                    ((out_cnt > OUT_MAX) ? OUT_MAX : int'(out_cnt));
                            for (j = 0; j < n_out; j++)
                            begin
                                acc = 64'sd0;
                                for (i = 0; i < n_in; i++)
                                begin
                                    acc = acc + in_vec[i] * weight_mem[i][j];
                                end
                                acc = acc + bias_mem[j] * 64'sd256;
                                if (acc <= 0)
                                begin
                                    want.level = '0;
                                end
                                else if ((acc >>> 8) > 64'sd32767)
                                begin
                                    want.level = 15'h7FFF;
                                end
                                else
                                begin
                                    want.level = acc[22:8];
                                end
                                want.neuron  = j[COL_W-1:0];
                                want.is_last = (j + 1 == n_out);
                                expected_outputs.push_back(want);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending = expected_outputs.size();
    end

endmodule

FILE: dv/dense_layer_relu_tb.sv
// ----------------------------------------------------------------------------
// dense_layer_relu_tb
// Stimulus and verdict for the dense layer with ReLU output. After a
// directed opening (saturation, zero and negative sums, ignored selector,
// input count lowered mid-vector) it runs phases of random settings, loads
// every weight and bias a vector needs, and sends vectors with reloads and
// noise mixed in, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module dense_layer_relu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dlr_pkg::*;

    localparam int IN_MAX       = 256;
    localparam int OUT_MAX      = 64;
    localparam int RANDOM_ITEMS = 330;
    localparam int HOLD_OFF     = 32;
    localparam int QUIET_LIMIT  = 4000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    req_t                   item_req     = REQ_WEIGHT;
    logic [ROW_W-1:0]       row_index    = '0;
    logic [COL_W-1:0]       column_index = '0;
    logic signed [VAL_W-1:0] value       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [RES_W-1:0]       out_value;
    logic [COL_W-1:0]       out_index;
    logic                   last;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CIDX_W-1:0]      cfg_index    = '0;
    logic [CNT_W-1:0]       cfg_data     = '0;
    int                     fail_count;
    int                     pending;

    bit                     calm = 1'b0;
    bit                     w_done [0:IN_MAX-1][0:OUT_MAX-1];
    bit                     b_done [0:OUT_MAX-1];
    int                     eff_in;
    int                     eff_out;
    int                     fill = 0;
    int                     sent = 0;
    int                     quiet = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dense_layer_relu #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX)) uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .req_type(item_req),
        .row_index(row_index), .column_index(column_index), .value(value),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_value(out_value), .out_index(out_index), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dense_layer_relu_checker #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX)) chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .req_type(item_req),
        .row_index(row_index), .column_index(column_index), .value(value),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_value(out_value), .out_index(out_index), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    // Ends the run when no transfer happens on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    function automatic int effective(input int raw, input int max);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > max) ? max : raw;
    endfunction

    task automatic send_item(input req_t rq, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        item_req     <= rq;
        row_index    <= r;
        column_index <= c;
        value        <= v;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic load_weight(input int r, input int c, input logic [VAL_W-1:0] v);
        send_item(REQ_WEIGHT, 8'(r), 6'(c), v);
        w_done[r][c] = 1'b1;
        sent++;
    endtask

    task automatic load_bias(input int c, input logic [VAL_W-1:0] v);
        send_item(REQ_BIAS, 8'($urandom), 6'(c), v);
        b_done[c] = 1'b1;
        sent++;
    endtask

    task automatic send_data(input logic [VAL_W-1:0] v);
        send_item(REQ_DATA, 8'($urandom), 6'($urandom), v);
        fill++;
        if (fill >= eff_in)
        begin
            fill = 0;
        end
        sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The sender holds off until every expected output has been taken.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] raw_in, input logic [CNT_W-1:0] raw_out);
        settle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(CFG_INPUT_COUNT, raw_in);
            write_reg(CFG_OUTPUT_COUNT, raw_out);
        end
        else
        begin
            write_reg(CFG_OUTPUT_COUNT, raw_out);
            write_reg(CFG_INPUT_COUNT, raw_in);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3, 9'($urandom));
        end
        eff_in  = effective(int'(raw_in), IN_MAX);
        eff_out = effective(int'(raw_out[OCNT_W-1:0]), OUT_MAX);
    endtask

    task automatic fill_missing();
        int r;
        int c;
        for (c = 0; c < eff_out; c++)
        begin
            for (r = 0; r < eff_in; r++)
            begin
                if (!w_done[r][c])
                begin
                    load_weight(r, c, pick_value());
                end
            end
            if (!b_done[c])
            begin
                load_bias(c, pick_value());
            end
        end
    endtask

    task automatic complete_vector();
        int k;
        do
        begin
            k = $urandom_range(0, 19);
            if (k < 3)
            begin
                load_weight($urandom_range(0, eff_in - 1), $urandom_range(0, eff_out - 1),
                            pick_value());
            end
            else if (k == 3)
            begin
                load_bias($urandom_range(0, eff_out - 1), pick_value());
            end
            else if (k == 4)
            begin
                load_weight($urandom_range(0, IN_MAX - 1), $urandom_range(0, OUT_MAX - 1),
                            pick_value());
            end
            else if (k == 5)
            begin
                send_item(REQ_NONE, 8'($urandom), 6'($urandom), 16'($urandom));
            end
            send_data(pick_value());
        end
        while (fill != 0);
    endtask

    initial
    begin : stimulus
        logic [CNT_W-1:0] raw_in;
        logic [CNT_W-1:0] raw_out;
        int               phase;
        int               k;
        int               tail;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(9'd3, 9'd2);
        load_weight(0, 0, 16'h7FFF);
        load_weight(1, 0, 16'h8000);
        load_weight(2, 0, 16'h0100);
        load_weight(0, 1, 16'h8000);
        load_weight(1, 1, 16'h8000);
        load_weight(2, 1, 16'h0001);
        load_bias(0, 16'h7FFF);
        load_bias(1, 16'h8000);
        send_item(REQ_NONE, 8'hFF, 6'h3F, 16'hFFFF);
        send_data(16'h7FFF);
        send_data(16'h8000);
        send_data(16'h7FFF);
        load_bias(1, 16'h0000);
        send_data(16'h0000);
        send_data(16'h0000);
        send_data(16'h0000);
        send_data(16'h0100);
        send_data(16'hFF00);
        configure(9'd2, 9'd2);
        send_data(16'h0080);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (phase >= 3 && phase <= 6);
            if (phase == 0)
            begin
                raw_in  = 9'd0;
                raw_out = 9'h1FF;
            end
            else if (phase == 1)
            begin
                raw_in  = 9'd4;
                raw_out = 9'd0;
            end
            else
            begin
                k = $urandom_range(0, 19);
                raw_in  = 9'($urandom_range(1, 8));
                raw_out = 9'($urandom_range(1, 8));
                if (k == 0)
                begin
                    raw_in = 9'd0;
                end
                else if (k == 1)
                begin
                    raw_out = 9'd0;
                end
                else if (k == 2)
                begin
                    raw_in  = 9'($urandom_range(1, 2));
                    raw_out = ($urandom_range(0, 1) == 0) ? 9'd64 : 9'd127;
                end
            end
            configure(raw_in, raw_out);
            fill_missing();
            repeat ((eff_in > 16) ? 1 : $urandom_range(1, 3)) complete_vector();
            if (eff_in > 1 && eff_in <= 16 && $urandom_range(0, 3) == 0)
            begin
                tail = $urandom_range(1, eff_in - 1);
                repeat (tail) send_data(pick_value());
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: dense_layer_relu.f
rtl/core/dlr_pkg.sv
rtl/core/dlr_ram.sv
rtl/core/dlr_mac.sv
rtl/core/dense_layer_relu.sv
dv/dense_layer_relu_checker.sv
dv/dense_layer_relu_tb.sv
